FILE: src/co2_level_alert_hysteresis_core_defines.svh
// Assertion macros shared by the CO2 alert core
`ifndef CO2_LEVEL_ALERT_HYSTERESIS_CORE_DEFINES_SVH
`define CO2_LEVEL_ALERT_HYSTERESIS_CORE_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define CO2LA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off during reset
`define CO2LA_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/co2la_pkg.sv
// Types, codes and reset values for the CO2 alert core
package co2la_pkg;

    localparam logic [2:0] LVL_OFF     = 3'd0;
    localparam logic [2:0] LVL_GREEN   = 3'd1;
    localparam logic [2:0] LVL_YELLOW  = 3'd2;
    localparam logic [2:0] LVL_ORANGE  = 3'd3;
    localparam logic [2:0] LVL_RED     = 3'd4;
    localparam logic [2:0] LVL_UNKNOWN = 3'd7;

    localparam logic [1:0] SND_NONE   = 2'd0;
    localparam logic [1:0] SND_ALARM  = 2'd1;
    localparam logic [1:0] SND_RELIEF = 2'd2;

    localparam logic [2:0] REG_LED_ENABLE     = 3'd0;
    localparam logic [2:0] REG_SOUND_ENABLE   = 3'd1;
    localparam logic [2:0] REG_ALERT_PPM      = 3'd2;
    localparam logic [2:0] REG_HYSTERESIS_PPM = 3'd3;
    localparam logic [2:0] REG_COOLDOWN_TICKS = 3'd4;
    localparam logic [2:0] REG_YELLOW_PPM     = 3'd5;
    localparam logic [2:0] REG_ORANGE_PPM     = 3'd6;
    localparam logic [2:0] REG_RED_PPM        = 3'd7;

    localparam logic [15:0] RST_ALERT_PPM      = 16'd1000;
    localparam logic [15:0] RST_HYSTERESIS_PPM = 16'd50;
    localparam logic [31:0] RST_COOLDOWN_TICKS = 32'd60000;
    localparam logic [15:0] RST_YELLOW_PPM     = 16'd800;
    localparam logic [15:0] RST_ORANGE_PPM     = 16'd1000;
    localparam logic [15:0] RST_RED_PPM        = 16'd1400;

    typedef struct packed {
        logic        led_enable;
        logic        sound_enable;
        logic [15:0] alert_ppm;
        logic [15:0] hysteresis_ppm;
        logic [31:0] cooldown_ticks;
        logic [15:0] yellow_ppm;
        logic [15:0] orange_ppm;
        logic [15:0] red_ppm;
    } t_cfg;

    typedef struct packed {
        logic        sensor_present;
        logic        status_valid;
        logic        sensor_frozen;
        logic [15:0] co2_ppm;
        logic [31:0] now_tick;
        logic        repaint;
    } t_item;

    function automatic logic reading_ok(input t_item item);
        return item.sensor_present && item.status_valid && !item.sensor_frozen
            && (item.co2_ppm != 16'd0);
    endfunction

endpackage

FILE: src/co2la_cfg.sv
// Configuration register file for the CO2 alert core
module co2la_cfg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    output co2la_pkg::t_cfg    o_cfg
);

    co2la_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.led_enable     <= 1'b1;
            r_cfg.sound_enable   <= 1'b1;
            r_cfg.alert_ppm      <= co2la_pkg::RST_ALERT_PPM;
            r_cfg.hysteresis_ppm <= co2la_pkg::RST_HYSTERESIS_PPM;
            r_cfg.cooldown_ticks <= co2la_pkg::RST_COOLDOWN_TICKS;
            r_cfg.yellow_ppm     <= co2la_pkg::RST_YELLOW_PPM;
            r_cfg.orange_ppm     <= co2la_pkg::RST_ORANGE_PPM;
            r_cfg.red_ppm        <= co2la_pkg::RST_RED_PPM;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                co2la_pkg::REG_LED_ENABLE:     r_cfg.led_enable     <= i_cfg_data[0];
                co2la_pkg::REG_SOUND_ENABLE:   r_cfg.sound_enable   <= i_cfg_data[0];
                co2la_pkg::REG_ALERT_PPM:      r_cfg.alert_ppm      <= i_cfg_data[15:0];
                co2la_pkg::REG_HYSTERESIS_PPM: r_cfg.hysteresis_ppm <= i_cfg_data[15:0];
                co2la_pkg::REG_COOLDOWN_TICKS: r_cfg.cooldown_ticks <= i_cfg_data;
                co2la_pkg::REG_YELLOW_PPM:     r_cfg.yellow_ppm     <= i_cfg_data[15:0];
                co2la_pkg::REG_ORANGE_PPM:     r_cfg.orange_ppm     <= i_cfg_data[15:0];
                co2la_pkg::REG_RED_PPM:        r_cfg.red_ppm        <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

endmodule

FILE: src/co2la_led.sv
// LED level classifier with cached shown level
module co2la_led (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  co2la_pkg::t_cfg    i_cfg,
    input  co2la_pkg::t_item   i_item,
    input  logic               i_adv,
    output logic [2:0]         o_level,
    output logic               o_update
);

    logic [2:0] r_shown;
    logic [2:0] n_shown;
    logic [2:0] w_cached;
    logic       w_on;

    assign w_on     = i_cfg.led_enable && co2la_pkg::reading_ok(i_item);
    assign w_cached = i_item.repaint ? co2la_pkg::LVL_UNKNOWN : r_shown;

    always_comb begin
        if (!w_on) begin
            o_level = co2la_pkg::LVL_OFF;
        end else if (i_item.co2_ppm < i_cfg.yellow_ppm) begin
            o_level = co2la_pkg::LVL_GREEN;
        end else if (i_item.co2_ppm < i_cfg.orange_ppm) begin
            o_level = co2la_pkg::LVL_YELLOW;
        end else if (i_item.co2_ppm < i_cfg.red_ppm) begin
            o_level = co2la_pkg::LVL_ORANGE;
        end else begin
            o_level = co2la_pkg::LVL_RED;
        end
    end

    assign o_update = (o_level != w_cached);
    assign n_shown  = i_adv ? o_level : r_shown;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shown <= co2la_pkg::LVL_UNKNOWN;
        end else begin
            r_shown <= n_shown;
        end
    end

endmodule

FILE: src/co2la_snd.sv
// Sound edge detector with hysteresis and cooldown
`include "co2_level_alert_hysteresis_core_defines.svh"

module co2la_snd (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  co2la_pkg::t_cfg    i_cfg,
    input  co2la_pkg::t_item   i_item,
    input  logic               i_adv,
    output logic [1:0]         o_sound
);

    logic        r_was_above;
    logic        n_was_above;
    logic [31:0] r_last_tick;
    logic [31:0] n_last_tick;
    logic        w_on;
    logic        w_above;
    logic [16:0] w_relief_thr;
    logic        w_below_relief;
    logic [31:0] w_elapsed;
    logic        w_expired;
    logic        w_rise;
    logic        w_fall;

    assign w_on           = i_cfg.sound_enable && co2la_pkg::reading_ok(i_item);
    assign w_above        = (i_item.co2_ppm >= i_cfg.alert_ppm);
    assign w_relief_thr   = {1'b0, i_cfg.alert_ppm} - {1'b0, i_cfg.hysteresis_ppm};
    assign w_below_relief = !w_relief_thr[16] && (i_item.co2_ppm < w_relief_thr[15:0]);
    assign w_elapsed      = i_item.now_tick - r_last_tick;
    assign w_expired      = (w_elapsed >= i_cfg.cooldown_ticks);

    // above and below relief exclude each other, so one edge at most
    assign w_rise = w_on && w_above && !r_was_above;
    assign w_fall = w_on && w_below_relief && r_was_above;

    always_comb begin
        if (w_rise && w_expired) begin
            o_sound = co2la_pkg::SND_ALARM;
        end else if (w_fall && w_expired) begin
            o_sound = co2la_pkg::SND_RELIEF;
        end else begin
            o_sound = co2la_pkg::SND_NONE;
        end
    end

    always_comb begin
        n_was_above = r_was_above;
        n_last_tick = r_last_tick;
        if (i_adv) begin
            if (w_rise) begin
                n_was_above = 1'b1;
            end else if (w_fall) begin
                n_was_above = 1'b0;
            end
            if (o_sound != co2la_pkg::SND_NONE) begin
                n_last_tick = i_item.now_tick;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_was_above <= 1'b0;
            r_last_tick <= 32'd0;
        end else begin
            r_was_above <= n_was_above;
            r_last_tick <= n_last_tick;
        end
    end

    `CO2LA_ASSERT_NXT(a_rise_sets_flag, i_adv && w_rise, r_was_above, "rising edge lost")
    `CO2LA_ASSERT_NXT(a_sound_stamps_tick, i_adv && (o_sound != co2la_pkg::SND_NONE),
                      r_last_tick == $past(i_item.now_tick), "sound tick not stored")

endmodule

FILE: src/co2_level_alert_hysteresis_core.sv
// Top level of the CO2 alert core: input register, classifier, sound unit, result register
// One item per clock unless i_ready holds the output: an item sits in the input register,
// LED and sound logic settle combinationally and the result lands in the result register,
// and items follow back to back while not stalled; the shown-level, edge-flag and last-
// sound registers update as the item leaves the input register, which closes the loop
// between consecutive items. Configuration writes are taken every cycle.
`include "co2_level_alert_hysteresis_core_defines.svh"

module co2_level_alert_hysteresis_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_sensor_present,
    input  logic        i_status_valid,
    input  logic        i_sensor_frozen,
    input  logic [15:0] i_co2_ppm,
    input  logic [31:0] i_now_tick,
    input  logic        i_repaint,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_led_level,
    output logic        o_led_update,
    output logic [1:0]  o_sound_event,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    co2la_pkg::t_cfg  w_cfg;
    co2la_pkg::t_item r_in;
    logic             r_in_vld;
    logic             r_out_vld;
    logic [2:0]       r_led_level;
    logic             r_led_update;
    logic [1:0]       r_sound;
    logic             w_adv;
    logic [2:0]       w_level;
    logic             w_update;
    logic [1:0]       w_sound;

    co2la_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    co2la_led u_led (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_item   (r_in),
        .i_adv    (w_adv),
        .o_level  (w_level),
        .o_update (w_update)
    );

    co2la_snd u_snd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_item  (r_in),
        .i_adv   (w_adv),
        .o_sound (w_sound)
    );

    assign w_adv   = r_in_vld && (!r_out_vld || i_ready);
    assign o_ready = !r_in_vld || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_vld <= i_valid;
            end
            if (w_adv) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in.sensor_present <= i_sensor_present;
            r_in.status_valid   <= i_status_valid;
            r_in.sensor_frozen  <= i_sensor_frozen;
            r_in.co2_ppm        <= i_co2_ppm;
            r_in.now_tick       <= i_now_tick;
            r_in.repaint        <= i_repaint;
        end
        if (w_adv) begin
            r_led_level  <= w_level;
            r_led_update <= w_update;
            r_sound      <= w_sound;
        end
    end

    assign o_valid       = r_out_vld;
    assign o_led_level   = r_led_level;
    assign o_led_update  = r_led_update;
    assign o_sound_event = r_sound;

    `CO2LA_ASSERT_IMP(a_full_stall_blocks, r_in_vld && r_out_vld && !i_ready, !o_ready,
                      "item taken while both stages stalled")
    `CO2LA_ASSERT_NXT(a_stage_holds, r_in_vld && !w_adv, r_in_vld, "held item dropped")
    `CO2LA_ASSERT_IMP(a_level_range, o_valid, o_led_level <= co2la_pkg::LVL_RED,
                      "LED level out of range")

endmodule
